>>> hdl/device_class_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the device class allocator
// Concurrent checks clocked on clk_i; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef DEVICE_CLASS_ALLOCATOR_CORE_DEFINES_SVH
`define DEVICE_CLASS_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define DCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define DCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define DCA_ASSERT(lbl, prop, msg)
`define DCA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/dca_pkg.sv
// ----------------------------------------------------------------------------
// dca_pkg
// Field types, status and request codes, register map of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dca_pkg;

  localparam int MAX_CLASSES = 3;
  localparam int BASE_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int MASK_W      = 16;
  localparam int JOB_W       = 8;
  localparam int TAG_W       = 8;
  localparam int DEV_W       = 4;
  localparam int FREED_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int CLASS_W     = 2;
  localparam int SCAN_W      = 5;   // base + count can reach 46; the core clips the scan end to the table size
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  typedef logic [BASE_W-1:0]   base_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [JOB_W-1:0]    job_t;
  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [DEV_W-1:0]    dev_t;
  typedef logic [FREED_W-1:0]  freed_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [SCAN_W-1:0]   scan_t;

  // request kind
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RECLAIM = 1'b1;

  // result status
  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_BAD_CLASS = 2'd1;
  localparam status_t STAT_NO_FREE   = 2'd2;
  localparam status_t STAT_NONE_HELD = 2'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_C0_BASE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_C0_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_C1_BASE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_C1_COUNT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C2_BASE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_C2_COUNT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_EN_MASK  = 3'd6;

  localparam base_t  BASE_RST  [MAX_CLASSES] = '{4'd0, 4'd2, 4'd5};
  localparam count_t COUNT_RST [MAX_CLASSES] = '{5'd2, 5'd3, 5'd4};
  localparam mask_t  MASK_RST                = 16'd1023;

endpackage

`default_nettype wire

>>> hdl/dca_if.sv
// ----------------------------------------------------------------------------
// dca_req_if / dca_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dca_req_if;
  import dca_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  class_t class_index;
  job_t   job_id;
  tag_t   relative_number;

  modport source (output valid, kind, class_index, job_id, relative_number, input ready);
  modport sink   (input valid, kind, class_index, job_id, relative_number, output ready);
endinterface

interface dca_rsp_if;
  import dca_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  dev_t    device_number;
  freed_t  freed_count;

  modport source (output valid, status, device_number, freed_count, input ready);
  modport sink   (input valid, status, device_number, freed_count, output ready);
endinterface

`default_nettype wire

>>> hdl/device_class_allocator_core.sv
// ----------------------------------------------------------------------------
// device_class_allocator_core
// Device table in three class ranges: allocate lowest free device, reclaim
// all devices of a job within a class.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          beat contents
//  req_i    in   valid/ready        kind, class_index, job_id, relative_number
//  rsp_o    out  valid/ready        status, device_number, freed_count
//  apb      in   psel/penable/pwr   paddr[4:2] register index, pwdata
//
//  An allocate scans the class range up to the first free device, or the
//  whole range when none is free; a reclaim scans every entry of the class
//  range. The reclaim scan walks one entry per cycle through the owner
//  table, whose read port is registered.
//  Reset clears flags and restores register defaults; no clearing pass.
//  A stalled result is held in the output register; the next request is
//  taken meanwhile and waits in its final step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "device_class_allocator_core_defines.svh"

module device_class_allocator_core #(
  parameter int NUM_DEVICES = 16,
  parameter int NUM_CLASSES = 3
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  dca_req_if.sink                    req_i,
  dca_rsp_if.source                  rsp_o,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [dca_pkg::ADDR_W-1:0]  paddr,
  input  wire [dca_pkg::DATA_W-1:0]  pwdata,
  output logic [dca_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import dca_pkg::*;

  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_RECL  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  // configuration
  base_t  base_q  [MAX_CLASSES];
  count_t count_q [MAX_CLASSES];
  mask_t  mask_q;
  count_t remain_q [MAX_CLASSES];

  // table
  logic   flag_q [NUM_DEVICES];
  job_t   owner_mem [NUM_DEVICES];
  tag_t   tag_mem   [NUM_DEVICES];
  job_t   owner_rd_q;

  // sequencer
  logic [1:0]       state_q, state_d;
  scan_t            cursor_q, cursor_d;
  scan_t            end_q, end_d;
  logic [1:0]       cls_q, cls_d;
  job_t             job_q, job_d;
  tag_t             tag_q, tag_d;
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;
  freed_t           freed_q, freed_d;
  status_t          res_stat_q, res_stat_d;
  dev_t             res_dev_q, res_dev_d;

  // output register
  logic    rsp_vld_q;
  status_t rsp_stat_q;
  dev_t    rsp_dev_q;
  freed_t  rsp_freed_q;

  logic             accept;
  logic             unknown_cls;
  logic [1:0]       cls_sel;
  logic [6:0]       end_sum;
  logic [IDX_W-1:0] idx;
  logic             dev_en;
  logic             mem_we;
  logic             flag_set;
  logic             flag_clr;
  logic             rem_dec;
  logic             rem_add;
  logic [5:0]       rem_sum;
  logic             fin_load;
  logic             cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  // --------------------------------------------------------------------------
  // config port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_C0_BASE:  prdata = DATA_W'(base_q[0]);
      REG_C0_COUNT: prdata = DATA_W'(count_q[0]);
      REG_C1_BASE:  prdata = DATA_W'(base_q[1]);
      REG_C1_COUNT: prdata = DATA_W'(count_q[1]);
      REG_C2_BASE:  prdata = DATA_W'(base_q[2]);
      REG_C2_COUNT: prdata = DATA_W'(count_q[2]);
      REG_EN_MASK:  prdata = DATA_W'(mask_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        base_q[c]  <= BASE_RST[c];
        count_q[c] <= COUNT_RST[c];
      end
      mask_q <= MASK_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_C0_BASE:  base_q[0]  <= pwdata[BASE_W-1:0];
        REG_C0_COUNT: count_q[0] <= pwdata[COUNT_W-1:0];
        REG_C1_BASE:  base_q[1]  <= pwdata[BASE_W-1:0];
        REG_C1_COUNT: count_q[1] <= pwdata[COUNT_W-1:0];
        REG_C2_BASE:  base_q[2]  <= pwdata[BASE_W-1:0];
        REG_C2_COUNT: count_q[2] <= pwdata[COUNT_W-1:0];
        REG_EN_MASK:  mask_q     <= pwdata[MASK_W-1:0];
        default:      ;
      endcase
    end
  end

  // remaining counts: count writes reload, allocate decrements,
  // reclaim adds the freed total with saturation
  assign rem_sum = {1'b0, remain_q[cls_q]} + {1'b0, freed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CLASSES; c++) remain_q[c] <= COUNT_RST[c];
    end else if (cfg_we) begin
      case (reg_idx)
        REG_C0_COUNT: remain_q[0] <= pwdata[COUNT_W-1:0];
        REG_C1_COUNT: remain_q[1] <= pwdata[COUNT_W-1:0];
        REG_C2_COUNT: remain_q[2] <= pwdata[COUNT_W-1:0];
        default:      ;
      endcase
    end else if (rem_dec) begin
      remain_q[cls_q] <= remain_q[cls_q] - 5'd1;
    end else if (rem_add) begin
      remain_q[cls_q] <= rem_sum[5] ? '1 : rem_sum[4:0];
    end
  end

  // --------------------------------------------------------------------------
  // request decode and scan sequencer
  // --------------------------------------------------------------------------
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign unknown_cls = (req_i.class_index >= 2'(NUM_CLASSES));
  assign cls_sel     = unknown_cls ? 2'd0 : req_i.class_index;
  assign end_sum     = 7'(base_q[cls_sel]) + 7'(count_q[cls_sel]);
  assign idx         = IDX_W'(cursor_q);
  // devices past the mask width are never usable
  assign dev_en      = (cursor_q < 5'(MASK_W)) && mask_q[cursor_q[DEV_W-1:0]];
  assign fin_load    = (state_q == S_FIN) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    cursor_d   = cursor_q;
    end_d      = end_q;
    cls_d      = cls_q;
    job_d      = job_q;
    tag_d      = tag_q;
    p_vld_d    = p_vld_q;
    p_idx_d    = p_idx_q;
    freed_d    = freed_q;
    res_stat_d = res_stat_q;
    res_dev_d  = res_dev_q;
    mem_we     = 1'b0;
    flag_set   = 1'b0;
    flag_clr   = 1'b0;
    rem_dec    = 1'b0;
    rem_add    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          job_d      = req_i.job_id;
          tag_d      = req_i.relative_number;
          cls_d      = cls_sel;
          cursor_d   = scan_t'(base_q[cls_sel]);
          end_d      = (end_sum > 7'(NUM_DEVICES)) ? scan_t'(NUM_DEVICES)
                                                   : end_sum[SCAN_W-1:0];
          freed_d    = '0;
          p_vld_d    = 1'b0;
          res_dev_d  = '0;
          res_stat_d = STAT_OK;
          if (unknown_cls) begin
            res_stat_d = STAT_BAD_CLASS;
            state_d    = S_FIN;
          end else if (req_i.kind == KIND_ALLOC) begin
            if (remain_q[cls_sel] == '0) begin
              res_stat_d = STAT_NO_FREE;
              state_d    = S_FIN;
            end else begin
              state_d = S_ALLOC;
            end
          end else begin
            state_d = S_RECL;
          end
        end
      end

      S_ALLOC: begin
        if (cursor_q >= end_q) begin
          res_stat_d = STAT_NO_FREE;
          state_d    = S_FIN;
        end else if (dev_en && !flag_q[idx]) begin
          flag_set   = 1'b1;
          mem_we     = 1'b1;
          rem_dec    = 1'b1;
          res_dev_d  = cursor_q[DEV_W-1:0];
          res_stat_d = STAT_OK;
          state_d    = S_FIN;
        end else begin
          cursor_d = cursor_q + 5'd1;
        end
      end

      S_RECL: begin
        // issue a read at the cursor, compare the entry read last cycle
        if (cursor_q < end_q) begin
          p_vld_d  = 1'b1;
          p_idx_d  = idx;
          cursor_d = cursor_q + 5'd1;
        end else begin
          p_vld_d = 1'b0;
        end
        if (p_vld_q && flag_q[p_idx_q] && (owner_rd_q == job_q)) begin
          flag_clr = 1'b1;
          freed_d  = freed_q + 5'd1;
        end
        if ((cursor_q >= end_q) && !p_vld_q) begin
          rem_add    = 1'b1;
          res_stat_d = (freed_q == '0) ? STAT_NONE_HELD : STAT_OK;
          state_d    = S_FIN;
        end
      end

      S_FIN: begin
        if (fin_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= '0;
      end_q    <= '0;
      cls_q    <= '0;
      p_vld_q  <= 1'b0;
      p_idx_q  <= '0;
      freed_q  <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      end_q    <= end_d;
      cls_q    <= cls_d;
      p_vld_q  <= p_vld_d;
      p_idx_q  <= p_idx_d;
      freed_q  <= freed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    tag_q      <= tag_d;
    res_stat_q <= res_stat_d;
    res_dev_q  <= res_dev_d;
  end

  // --------------------------------------------------------------------------
  // device table
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_DEVICES; d++) flag_q[d] <= 1'b0;
    end else begin
      if (flag_set) flag_q[idx]     <= 1'b1;
      if (flag_clr) flag_q[p_idx_q] <= 1'b0;
    end
  end

  // owner/tag only matter where the flag is set, so no reset
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem[idx] <= job_q;
      tag_mem[idx]   <= tag_q;
    end
    owner_rd_q <= owner_mem[idx];
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (fin_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      rsp_stat_q  <= res_stat_q;
      rsp_dev_q   <= res_dev_q;
      rsp_freed_q <= freed_q;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_stat_q;
  assign rsp_o.device_number = rsp_dev_q;
  assign rsp_o.freed_count   = rsp_freed_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `DCA_ASSERT(a_alloc_in_range, (state_q == S_ALLOC) |-> (cursor_q <= end_q), "alloc scan past range")
  `DCA_ASSERT(a_recl_idx_ok, (state_q == S_RECL && p_vld_q) |-> (32'(p_idx_q) < NUM_DEVICES), "reclaim index out of table")
  `DCA_ASSERT(a_fin_loads_rsp, fin_load |=> (rsp_vld_q && state_q == S_IDLE), "result not loaded on finish")
  `DCA_ASSERT(a_busy_after_accept, accept |=> !req_i.ready, "request taken while busy")
  `DCA_ASSERT_ALWAYS(a_none_held_zero, (rsp_vld_q && rsp_stat_q == STAT_NONE_HELD) |-> (rsp_freed_q == '0), "none-held with nonzero count")

endmodule

`default_nettype wire

>>> tb/sv/tb_device_class_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_device_class_allocator_core
// Self-checking bench for the class-partitioned device table. Directed cases
// cover reset defaults, clipped and overlapping ranges, disabled devices and
// remaining-count saturation. Random phases then reprogram the registers and
// run allocate/reclaim traffic from small job pools under random stalls on
// both channels, plus one long result back-pressure burst. Every result beat
// is checked against a behavioral copy of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_device_class_allocator_core;
  import dca_pkg::*;

  localparam int NUM_DEV      = 16;
  localparam int NUM_CLS      = 3;
  localparam int MAX_GAP      = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT    = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam class_t CLASS_0       = 2'd0;
  localparam class_t CLASS_1       = 2'd1;
  localparam class_t CLASS_2       = 2'd2;
  localparam class_t CLASS_UNKNOWN = 2'd3;

  typedef struct packed {
    logic   kind;
    class_t cls;
    job_t   job;
    tag_t   tag;
  } request_t;

  typedef struct packed {
    status_t status;
    dev_t    dev;
    freed_t  freed;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  dca_req_if req_bus ();
  dca_rsp_if rsp_bus ();

  device_class_allocator_core #(
    .NUM_DEVICES(NUM_DEV),
    .NUM_CLASSES(NUM_CLS)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // table copy kept by the bench
  base_t   cls_base  [NUM_CLS];
  count_t  cls_count [NUM_CLS];
  count_t  remaining [NUM_CLS];
  mask_t   en_mask;
  logic    dev_busy  [NUM_DEV];
  job_t    dev_owner [NUM_DEV];
  tag_t    dev_tag   [NUM_DEV];

  result_t expected_q [$];

  bit tx_idle;
  bit rx_idle;
  int rx_hold;
  int cycles;
  int n_fail;
  int n_checked;
  int n_reg_writes;
  int n_req_stalls;
  int n_kind   [2];
  int n_status [4];

  function automatic void table_reset();
    for (int c = 0; c < NUM_CLS; c++) begin
      cls_base[c]  = BASE_RST[c];
      cls_count[c] = COUNT_RST[c];
      remaining[c] = COUNT_RST[c];
    end
    en_mask = MASK_RST;
    for (int d = 0; d < NUM_DEV; d++) begin
      dev_busy[d]  = 1'b0;
      dev_owner[d] = '0;
      dev_tag[d]   = '0;
    end
  endfunction

  function automatic void table_config(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    case (idx)
      REG_C0_BASE:  cls_base[0] = val[BASE_W-1:0];
      REG_C1_BASE:  cls_base[1] = val[BASE_W-1:0];
      REG_C2_BASE:  cls_base[2] = val[BASE_W-1:0];
      REG_C0_COUNT: begin
        cls_count[0] = val[COUNT_W-1:0];
        remaining[0] = val[COUNT_W-1:0];
      end
      REG_C1_COUNT: begin
        cls_count[1] = val[COUNT_W-1:0];
        remaining[1] = val[COUNT_W-1:0];
      end
      REG_C2_COUNT: begin
        cls_count[2] = val[COUNT_W-1:0];
        remaining[2] = val[COUNT_W-1:0];
      end
      REG_EN_MASK:  en_mask = val[MASK_W-1:0];
      default: ;
    endcase
  endfunction

  // Applies one request to the table copy and returns the result it yields.
  function automatic result_t table_apply(request_t r);
    result_t res;
    int      first;
    int      last;
    int      slot;
    int      freed;
    int      total;
    bit      found;
    res = '0;
    if (r.cls >= NUM_CLS) begin
      res.status = STAT_BAD_CLASS;
      return res;
    end
    first = cls_base[r.cls];
    last  = first + cls_count[r.cls];
    if (last > NUM_DEV) last = NUM_DEV;
    if (r.kind == KIND_ALLOC) begin
      found = 1'b0;
      slot  = 0;
      if (remaining[r.cls] != 0) begin
        for (int d = first; d < last; d++) begin
          if (en_mask[d] && !dev_busy[d]) begin
            found = 1'b1;
            slot  = d;
            break;
          end
        end
      end
      if (found) begin
        remaining[r.cls] = remaining[r.cls] - 1'b1;
        dev_busy[slot]   = 1'b1;
        dev_owner[slot]  = r.job;
        dev_tag[slot]    = r.tag;
        res.status       = STAT_OK;
        res.dev          = dev_t'(slot);
      end else begin
        res.status = STAT_NO_FREE;
      end
    end else begin
      freed = 0;
      for (int d = first; d < last; d++) begin
        if (dev_busy[d] && dev_owner[d] == r.job) begin
          dev_busy[d] = 1'b0;
          freed++;
        end
      end
      total = remaining[r.cls] + freed;
      if (total > 31) total = 31;   // count saturates
      remaining[r.cls] = count_t'(total);
      res.freed  = freed_t'(freed);
      res.status = (freed == 0) ? STAT_NONE_HELD : STAT_OK;
    end
    return res;
  endfunction

  // Offers one request; the valid stays up after the beat so a zero gap
  // on the next call streams back to back.
  task automatic send_request(logic kind, class_t cls, job_t job, tag_t tag);
    int       gap;
    request_t r;
    result_t  res;
    gap = tx_idle ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid           <= 1'b1;
    req_bus.kind            <= kind;
    req_bus.class_index     <= cls;
    req_bus.job_id          <= job;
    req_bus.relative_number <= tag;
    do @(posedge clk); while (!req_bus.ready);
    r   = '{kind: kind, cls: cls, job: job, tag: tag};
    res = table_apply(r);
    expected_q.push_back(res);
    n_kind[kind]++;
    n_status[res.status]++;
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    table_config(idx, val);
    n_reg_writes++;
  endtask

  // Bits above each register's width carry junk; only the low bits count.
  task automatic program_table(base_t b0, count_t c0, base_t b1, count_t c1,
                               base_t b2, count_t c2, mask_t m);
    reg_write(REG_C0_BASE,  ($urandom() << BASE_W)  | DATA_W'(b0));
    reg_write(REG_C0_COUNT, ($urandom() << COUNT_W) | DATA_W'(c0));
    reg_write(REG_C1_BASE,  ($urandom() << BASE_W)  | DATA_W'(b1));
    reg_write(REG_C1_COUNT, ($urandom() << COUNT_W) | DATA_W'(c1));
    reg_write(REG_C2_BASE,  ($urandom() << BASE_W)  | DATA_W'(b2));
    reg_write(REG_C2_COUNT, ($urandom() << COUNT_W) | DATA_W'(c2));
    reg_write(REG_EN_MASK,  ($urandom() << MASK_W)  | DATA_W'(m));
    reg_write(REG_UNMAPPED, $urandom());
  endtask

  // class 0 must span the whole table when this runs
  task automatic release_all();
    for (int d = 0; d < NUM_DEV; d++) begin
      if (dev_busy[d])
        send_request(KIND_RECLAIM, CLASS_0, dev_owner[d], tag_t'($urandom_range(255, 0)));
    end
  endtask

  task automatic test_reset_defaults();
    send_request(KIND_ALLOC,   CLASS_0,       8'h00, 8'h00);
    send_request(KIND_ALLOC,   CLASS_0,       8'hFF, 8'hFF);
    send_request(KIND_ALLOC,   CLASS_0,       8'h33, 8'h01);   // remaining at zero
    send_request(KIND_ALLOC,   CLASS_UNKNOWN, 8'h12, 8'h34);
    send_request(KIND_RECLAIM, CLASS_UNKNOWN, 8'hFF, 8'h00);
    send_request(KIND_RECLAIM, CLASS_0,       8'h07, 8'h00);   // job held none
    send_request(KIND_RECLAIM, CLASS_0,       8'hFF, 8'h80);
    send_request(KIND_ALLOC,   CLASS_1,       8'h5A, 8'hA5);
    send_request(KIND_ALLOC,   CLASS_2,       8'hA5, 8'h5A);
    wait_drained();
  endtask

  // class 0 runs past the end of the table, class 1 overlaps it, class 2 empty
  task automatic test_range_edges();
    program_table(4'd12, 5'd16, 4'd15, 5'd1, 4'd3, 5'd0, 16'hFFFF);
    send_request(KIND_ALLOC,   CLASS_0, 8'h81, 8'h11);
    send_request(KIND_ALLOC,   CLASS_0, 8'h81, 8'h22);
    send_request(KIND_ALLOC,   CLASS_0, 8'h81, 8'h44);
    send_request(KIND_ALLOC,   CLASS_0, 8'h42, 8'h88);
    send_request(KIND_ALLOC,   CLASS_0, 8'h81, 8'h10);   // range exhausted
    send_request(KIND_ALLOC,   CLASS_1, 8'h01, 8'h02);
    send_request(KIND_ALLOC,   CLASS_2, 8'h01, 8'h02);
    send_request(KIND_RECLAIM, CLASS_1, 8'h42, 8'h00);
    send_request(KIND_RECLAIM, CLASS_0, 8'h81, 8'h00);
    wait_drained();
  endtask

  task automatic test_count_saturation();
    program_table(4'd0, 5'd16, 4'd0, 5'd16, 4'd0, 5'd16, 16'hFFFF);
    release_all();
    for (int i = 0; i < NUM_DEV; i++)
      send_request(KIND_ALLOC, CLASS_0, 8'h3C, tag_t'(i));
    wait_drained();
    reg_write(REG_C0_COUNT, DATA_W'(16));
    send_request(KIND_RECLAIM, CLASS_0, 8'h3C, 8'h00);   // 16 + 16 clips to 31
    send_request(KIND_ALLOC,   CLASS_0, 8'h3C, 8'hC3);
    wait_drained();
  endtask

  task automatic test_disabled_reclaim();
    program_table(4'd0, 5'd16, 4'd4, 5'd4, 4'd8, 5'd8, 16'hFFFF);
    send_request(KIND_ALLOC, CLASS_1, 8'h11, 8'h01);
    send_request(KIND_ALLOC, CLASS_2, 8'h11, 8'h02);
    wait_drained();
    reg_write(REG_EN_MASK, DATA_W'(16'h0000));
    send_request(KIND_ALLOC,   CLASS_1, 8'h11, 8'h03);
    send_request(KIND_RECLAIM, CLASS_1, 8'h11, 8'h00);
    send_request(KIND_RECLAIM, CLASS_2, 8'h11, 8'h00);
    wait_drained();
  endtask

  // Results held off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    program_table(4'd0, 5'd4, 4'd4, 5'd4, 4'd8, 5'd8, 16'hFFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = HOLD_CYCLES;
    for (int i = 0; i < 24; i++)
      send_request(i[0] ? KIND_RECLAIM : KIND_ALLOC, class_t'($urandom_range(2, 0)),
                   job_t'($urandom_range(3, 0)), tag_t'($urandom_range(255, 0)));
    wait_drained();
  endtask

  task automatic test_random_phase(int phase);
    job_t   pool [4];
    base_t  b [NUM_CLS];
    count_t c [NUM_CLS];
    mask_t  m;
    logic   kind;
    class_t cls;
    job_t   job;
    for (int i = 0; i < 4; i++) pool[i] = job_t'($urandom_range(255, 0));
    for (int k = 0; k < NUM_CLS; k++) begin
      b[k] = base_t'($urandom_range(15, 0));
      case ($urandom_range(7, 0))
        0:       c[k] = 5'd0;
        1, 2:    c[k] = 5'd16;
        default: c[k] = count_t'($urandom_range(8, 1));
      endcase
    end
    case ($urandom_range(3, 0))
      0:       m = 16'hFFFF;
      1:       m = mask_t'($urandom());
      2:       m = mask_t'($urandom() | $urandom());
      default: m = MASK_RST;
    endcase
    if (phase == 0) begin
      program_table(4'd0, 5'd16, 4'd0, 5'd16, 4'd0, 5'd16, 16'hFFFF);
    end else if (phase == 1) begin
      program_table(4'd15, 5'd16, 4'd15, 5'd1, 4'd0, 5'd0, 16'hFFFF);
    end else begin
      program_table(b[0], c[0], b[1], c[1], b[2], c[2], m);
    end
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 25 == 0) begin
        tx_idle = ($urandom_range(2, 0) != 0);
        rx_idle = ($urandom_range(2, 0) != 0);
      end
      kind = ($urandom_range(9, 0) < 4) ? KIND_RECLAIM : KIND_ALLOC;
      cls  = ($urandom_range(15, 0) == 0) ? CLASS_UNKNOWN
                                           : class_t'($urandom_range(NUM_CLS - 1, 0));
      job  = ($urandom_range(7, 0) == 0) ? job_t'($urandom_range(255, 0))
                                         : pool[$urandom_range(3, 0)];
      send_request(kind, cls, job, tag_t'($urandom_range(255, 0)));
    end
    wait_drained();
  endtask

  // result channel ready, one stall draw per beat
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(MAX_GAP, 0) : 0;
        if (stall > 0) begin
          rsp_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
    end
  end

  always @(posedge clk) begin : check_results
    result_t exp;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("[%0d] unexpected result beat: status %0d dev %0d freed %0d",
                   cycles, rsp_bus.status, rsp_bus.device_number, rsp_bus.freed_count);
      end else begin
        exp = expected_q.pop_front();
        n_checked++;
        if (rsp_bus.status !== exp.status || rsp_bus.device_number !== exp.dev ||
            rsp_bus.freed_count !== exp.freed) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("[%0d] result %0d mismatch: status %0d/%0d dev %0d/%0d freed %0d/%0d",
                     cycles, n_checked, exp.status, rsp_bus.status, exp.dev,
                     rsp_bus.device_number, exp.freed, rsp_bus.freed_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && req_bus.valid && !req_bus.ready) n_req_stalls <= n_req_stalls + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycles       = 0;
    n_fail       = 0;
    n_checked    = 0;
    n_reg_writes = 0;
    n_req_stalls = 0;
    n_kind       = '{0, 0};
    n_status     = '{0, 0, 0, 0};
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_hold      = 0;
    table_reset();
    rst_n                   <= 1'b0;
    req_bus.valid           <= 1'b0;
    req_bus.kind            <= KIND_ALLOC;
    req_bus.class_index     <= CLASS_0;
    req_bus.job_id          <= '0;
    req_bus.relative_number <= '0;
    rsp_bus.ready           <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_range_edges();
    test_count_saturation();
    test_disabled_reclaim();
    test_backpressure();
    for (int p = 0; p < RAND_PHASES; p++) test_random_phase(p);

    $display("covered %0d requests (%0d allocate, %0d reclaim), %0d register writes",
             n_kind[0] + n_kind[1], n_kind[0], n_kind[1], n_reg_writes);
    $display("status ok %0d, bad class %0d, no free %0d, none held %0d; %0d stalled cycles",
             n_status[0], n_status[1], n_status[2], n_status[3], n_req_stalls);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results never seen", n_fail, expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
